### rtl/core/mbdc_pkg.sv
// Package for the MPPT boost duty controller: beat structs, config struct,
// register indexes, sequencer states and shared constants. No dependencies.
package mbdc_pkg;

  localparam int unsigned DIV_W     = 33;  // dividend / quotient width
  localparam int unsigned DVS_W     = 16;  // divisor / remainder width
  localparam int unsigned DIV_CNT_W = 6;   // step counter width

  localparam logic [5:0]  DIV_STEPS_SP   = 6'd33;
  localparam logic [5:0]  DIV_STEPS_DUTY = 6'd17;
  localparam logic [16:0] DUTY_ONE       = 17'd65536;
  localparam logic [15:0] SP_MAX         = 16'hFFFF;

  localparam logic [31:0] RST_POWER_THR  = 32'd50000;
  localparam logic [16:0] RST_DUTY_MIN   = 17'd0;
  localparam logic [16:0] RST_DUTY_MAX   = 17'd58982;
  localparam logic [15:0] RST_PWM_PERIOD = 16'd65535;
  localparam logic [15:0] RST_INIT_SP    = 16'd0;

  typedef enum logic [2:0] {
    CFG_POWER_THR = 3'd0,
    CFG_DUTY_MIN  = 3'd1,
    CFG_DUTY_MAX  = 3'd2,
    CFG_PWM_PER   = 3'd3,
    CFG_INIT_SP   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_MAG,
    ST_TEST,
    ST_DIV_SP,
    ST_SP,
    ST_CHK,
    ST_DIV_DUTY,
    ST_CLAMP,
    ST_SCALE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [15:0]        bat_voltage_mv;
    logic signed [15:0] bat_current_ma;
    logic [15:0]        panel_voltage_mv;
  } in_t;

  typedef struct packed {
    logic [15:0]        compare_value;
    logic [15:0]        setpoint_mv;
    logic [16:0]        duty_q16;
    logic signed [31:0] power_uw;
    logic               setpoint_moved;
    logic               duty_error;
  } out_t;

  typedef struct packed {
    logic [31:0] power_threshold_uw;
    logic [16:0] duty_min_q16;
    logic [16:0] duty_max_q16;
    logic [15:0] pwm_period;
    logic [15:0] initial_setpoint_mv;
  } cfg_t;

  // Divider request: bits to consume sit at the top of dividend.
  typedef struct packed {
    logic [DIV_W-1:0]     dividend;
    logic [DVS_W-1:0]     rem_init;
    logic [DVS_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  function automatic logic [16:0] sat_duty(input logic [16:0] v);
    sat_duty = (v > DUTY_ONE) ? DUTY_ONE : v;
  endfunction

endpackage

### rtl/core/mppt_boost_duty_control.sv
// Top level of the perturb-and-observe MPPT boost duty controller.
// Depends on mbdc_pkg, mbdc_cfg and mbdc_div.
//
// One measurement beat in (battery mV, signed battery mA, panel mV), one
// result beat out. Power is vbat*current in uW. When |dP| since the last
// beat exceeds power_threshold_uw, the setpoint moves to panel voltage plus
// dP/dV (truncated, zero when dV is zero, saturated to 0..65535). The duty
// (vbat - setpoint)/vbat in Q1.16 is clamped (max tested first, then min)
// and scaled by pwm_period into the compare value. Zero vbat or a setpoint
// above vbat sets duty_error and holds the previous duty and compare value.
// The result beat skips the divider on the error path without a setpoint
// move and waits on both divisions when the setpoint moves with nonzero dV
// and the duty is divided; the sequencer then returns to idle, where the
// next beat is taken. The pace is set by the single shared restoring
// divider: 33 quotient bits for dP/dV and 17 for the duty fraction, one
// quotient bit per cycle. in_stall_o is high while a beat is in flight; a
// finished result sits in the output register while the next beat is
// taken, and the sequencer waits in its done state only if that register
// is still full and stalled. Config writes are expected only while idle;
// writing initial_setpoint_mv also loads the live setpoint.
module mppt_boost_duty_control (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbdc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbdc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);
  import mbdc_pkg::*;

  cfg_t     cfg;
  state_e   state_q, state_d;
  div_req_t div_req;
  logic     div_start;
  logic     div_done;
  logic [DIV_W-1:0] div_quot;

  // captured beat
  logic [15:0]        vbat_q;
  logic signed [15:0] cur_q;
  logic [15:0]        vpan_q;

  // working registers
  logic signed [31:0] power_q;
  logic signed [32:0] dp_q;
  logic signed [16:0] dv_q;
  logic [32:0]        mag_q;
  logic [15:0]        dv_abs_q;
  logic [32:0]        quot_q;

  // architectural state
  logic signed [31:0] prev_power_q;
  logic [15:0]        prev_vpan_q;
  logic [15:0]        setpoint_q;
  logic [16:0]        duty_q;
  logic [15:0]        compare_q;
  logic               moved_q;
  logic               err_q;

  logic               out_valid_q;
  out_t               out_data_q;

  logic               in_accept;
  logic               out_free;
  logic               moved_now;
  logic signed [32:0] power_prod;
  logic signed [32:0] dp_calc;
  logic signed [16:0] dv_calc;
  logic               q_neg;
  logic [33:0]        sp_sum;
  logic [15:0]        sp_new;
  logic [15:0]        duty_diff;
  logic               err_now;
  logic [16:0]        duty_raw;
  logic [16:0]        duty_clamped;
  logic [32:0]        cmp_prod;

  mbdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mbdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // --- datapath arithmetic, one wide op per state ---
  assign power_prod = $signed({1'b0, vbat_q}) * cur_q;
  assign dp_calc    = {power_q[31], power_q} - {prev_power_q[31], prev_power_q};
  assign dv_calc    = $signed({1'b0, vpan_q}) - $signed({1'b0, prev_vpan_q});
  assign moved_now  = mag_q > {1'b0, cfg.power_threshold_uw};

  // setpoint = vpan +/- |quotient|, saturated
  assign q_neg  = dp_q[32] ^ dv_q[16];
  assign sp_sum = {1'b0, quot_q} + {18'd0, vpan_q};
  always_comb begin
    if (q_neg) begin
      sp_new = (quot_q > {17'd0, vpan_q}) ? 16'd0 : (vpan_q - quot_q[15:0]);
    end else begin
      sp_new = (sp_sum > {18'd0, SP_MAX}) ? SP_MAX : sp_sum[15:0];
    end
  end

  assign err_now   = (vbat_q == 16'd0) || (setpoint_q > vbat_q);
  assign duty_diff = vbat_q - setpoint_q;

  assign duty_raw = div_quot[16:0];
  always_comb begin
    if (duty_raw > cfg.duty_max_q16) begin
      duty_clamped = cfg.duty_max_q16;
    end else if (duty_raw < cfg.duty_min_q16) begin
      duty_clamped = cfg.duty_min_q16;
    end else begin
      duty_clamped = duty_raw;
    end
  end

  assign cmp_prod = cfg.pwm_period * duty_q;

  // --- sequencer ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_req   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MAG;
      ST_MAG:  state_d = ST_TEST;
      ST_TEST: begin
        if (!moved_now) begin
          state_d = ST_CHK;
        end else if (dv_q == 17'sd0) begin
          state_d = ST_SP;
        end else begin
          // |dP| / |dV|, all 33 dividend bits
          div_start        = 1'b1;
          div_req.dividend = mag_q;
          div_req.rem_init = '0;
          div_req.divisor  = dv_abs_q;
          div_req.steps    = DIV_STEPS_SP;
          state_d          = ST_DIV_SP;
        end
      end
      ST_DIV_SP: begin
        if (div_done) state_d = ST_SP;
      end
      ST_SP:   state_d = ST_CHK;
      ST_CHK: begin
        if (err_now) begin
          state_d = ST_DONE;
        end else begin
          // (diff << 16) / vbat: quotient is at most 17 bits, so the top
          // 15 dividend bits preload the remainder and 17 steps remain
          div_start        = 1'b1;
          div_req.dividend = {duty_diff[0], 32'd0};
          div_req.rem_init = {1'b0, duty_diff[15:1]};
          div_req.divisor  = vbat_q;
          div_req.steps    = DIV_STEPS_DUTY;
          state_d          = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        if (div_done) state_d = ST_CLAMP;
      end
      ST_CLAMP: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --- working registers (no reset needed) ---
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vbat_q <= in_data_i.bat_voltage_mv;
      cur_q  <= in_data_i.bat_current_ma;
      vpan_q <= in_data_i.panel_voltage_mv;
    end
    if (state_q == ST_MUL) begin
      power_q <= power_prod[31:0];
    end
    if (state_q == ST_DIFF) begin
      dp_q <= dp_calc;
      dv_q <= dv_calc;
    end
    if (state_q == ST_MAG) begin
      mag_q    <= dp_q[32] ? 33'(-dp_q) : dp_q;
      dv_abs_q <= dv_q[16] ? 16'(-dv_q) : dv_q[15:0];
    end
    if (state_q == ST_TEST) begin
      quot_q <= '0;
    end else if (state_q == ST_DIV_SP && div_done) begin
      quot_q <= div_quot;
    end
  end

  // --- architectural state ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_power_q <= '0;
      prev_vpan_q  <= '0;
      setpoint_q   <= RST_INIT_SP;
      duty_q       <= RST_DUTY_MIN;
      compare_q    <= '0;
      moved_q      <= 1'b0;
      err_q        <= 1'b0;
    end else begin
      if (state_q == ST_MAG) begin
        // previous sample updates every beat
        prev_power_q <= power_q;
        prev_vpan_q  <= vpan_q;
      end
      if (state_q == ST_TEST) begin
        moved_q <= moved_now;
      end
      if (state_q == ST_SP) begin
        setpoint_q <= sp_new;
      end else if (cfg_we_i && cfg_idx_i == CFG_INIT_SP) begin
        setpoint_q <= cfg_wdata_i[15:0];
      end
      if (state_q == ST_CHK) begin
        err_q <= err_now;
      end
      if (state_q == ST_CLAMP) begin
        duty_q <= duty_clamped;
      end
      if (state_q == ST_SCALE) begin
        compare_q <= cmp_prod[31:16];
      end
    end
  end

  // --- output register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_data_q.compare_value  <= compare_q;
      out_data_q.setpoint_mv    <= setpoint_q;
      out_data_q.duty_q16       <= duty_q;
      out_data_q.power_uw       <= power_q;
      out_data_q.setpoint_moved <= moved_q;
      out_data_q.duty_error     <= err_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/mbdc_cfg.sv
// Configuration register file for the MPPT duty controller.
// Depends on mbdc_pkg.
module mbdc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output mbdc_pkg::cfg_t     cfg_o
);
  import mbdc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_threshold_uw  <= RST_POWER_THR;
      cfg_q.duty_min_q16        <= RST_DUTY_MIN;
      cfg_q.duty_max_q16        <= RST_DUTY_MAX;
      cfg_q.pwm_period          <= RST_PWM_PERIOD;
      cfg_q.initial_setpoint_mv <= RST_INIT_SP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POWER_THR: cfg_q.power_threshold_uw  <= cfg_wdata_i;
        CFG_DUTY_MIN:  cfg_q.duty_min_q16        <= sat_duty(cfg_wdata_i[16:0]);
        CFG_DUTY_MAX:  cfg_q.duty_max_q16        <= sat_duty(cfg_wdata_i[16:0]);
        CFG_PWM_PER:   cfg_q.pwm_period          <= cfg_wdata_i[15:0];
        CFG_INIT_SP:   cfg_q.initial_setpoint_mv <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/mbdc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mbdc_pkg.
module mbdc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mbdc_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [mbdc_pkg::DIV_W-1:0]  quot_o
);
  import mbdc_pkg::*;

  logic [DIV_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DVS_W:0]       trial;
  logic                 fits;
  logic [DVS_W:0]       trial_sub;

  assign trial     = {rem_q, dvd_q[DIV_W-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so the trial fits in DVS_W+1 bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= req_i.dividend;
      rem_q <= req_i.rem_init;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], fits};
      rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

### rtl/core/mbdc_checker.sv
// Port-level checker for the MPPT duty controller, bound to the top level.
// Depends on mbdc_pkg and mppt_boost_duty_control.
module mbdc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mbdc_pkg::out_t out_data_o
);
  import mbdc_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a taken beat keeps the input stalled while the sequencer runs
  a_busy_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  a_busy_later: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##4 in_stall_o)
    else $error("sequencer finished too early");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_q16 <= DUTY_ONE)
    else $error("duty above one");

endmodule

bind mppt_boost_duty_control mbdc_checker u_mbdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
